### hdl/dark_mode_colour_remap_unit_defines.svh
// ---------------------------------------------------------------------------
// Dark mode colour remap: assertion macros
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef DARK_MODE_COLOUR_REMAP_UNIT_DEFINES_SVH
`define DARK_MODE_COLOUR_REMAP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMCR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold the delay lat after the antecedent.
`define DMCR_ASSERT_LAT(name, ante, lat, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##lat (cons)) \
    else $error(msg);

`endif

### hdl/dmcr_pkg.sv
// ---------------------------------------------------------------------------
// Dark mode colour remap package
// Fixed-point constants, register indexes and small arithmetic helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package dmcr_pkg;

  localparam int unsigned ONE_Q16   = 65536;
  localparam int unsigned TWO_Q16   = 131072;
  localparam int unsigned SIX_Q16   = 393216;
  localparam int unsigned LATENCY   = 7;

  // floor(sum * 65536 / 510) == (sum * RECIP_255) >> 17 for every sum in 0..510.
  localparam logic [24:0] RECIP_255 = 25'd16843010;

  localparam logic [2:0] REG_HIGH_CONTRAST = 3'd0;
  localparam logic [2:0] REG_FORE_LEVEL    = 3'd1;
  localparam logic [2:0] REG_FORE_FLOOR    = 3'd2;
  localparam logic [2:0] REG_BACK_LEVEL    = 3'd3;
  localparam logic [2:0] REG_BACK_CEILING  = 3'd4;

  localparam logic [9:0] FORE_LEVEL_RST   = 10'd768;
  localparam logic [9:0] FORE_FLOOR_RST   = 10'd870;
  localparam logic [9:0] BACK_LEVEL_RST   = 10'd205;
  localparam logic [9:0] BACK_CEILING_RST = 10'd51;

  localparam logic CMD_FORE = 1'b0;
  localparam logic CMD_BACK = 1'b1;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic [7:0] dsr);
    logic [8:0] t;
    logic [8:0] diff;
    t    = {rem, 1'b0};
    diff = t - {1'b0, dsr};
    if (t >= {1'b0, dsr}) begin
      return {1'b1, diff[7:0]};
    end
    return {1'b0, t[7:0]};
  endfunction

  // Clamp a Q16 channel to 0..1 and scale it to 0..255 with truncation.
  function automatic logic [7:0] to_byte(input logic signed [18:0] v);
    logic [16:0] vc;
    logic [24:0] prod;
    if (v < 0) begin
      vc = '0;
    end else if (v > 19'sd65536) begin
      vc = 17'd65536;
    end else begin
      vc = v[16:0];
    end
    prod = {vc, 8'b0} - {8'b0, vc};
    return prod[23:16];
  endfunction

endpackage

`default_nettype wire

### hdl/dark_mode_colour_remap_unit.sv
// ---------------------------------------------------------------------------
// Dark mode colour remap unit
// RGB to HSL, lightness replacement, HSL back to RGB, one pixel per clock.
// ---------------------------------------------------------------------------
// A pixel is taken on every clock edge where start_i is high; busy_o is held
// low, so one pixel per clock is sustained. Its result appears on the output
// ports after the last stage, marked by a one-cycle result_valid_o, in input
// order. The receiver cannot stall the block. The pipeline has seven
// register stages: the first sorts the channels, the next three carry
// the two 17-bit quotient dividers (hue and saturation) beside the lightness
// scaling and replacement, stages five and six hold the two multipliers of
// the back conversion, and the last places the channels and scales them to
// bytes. Registers may only be written while no pixel is in flight.
`default_nettype none

`include "dark_mode_colour_remap_unit_defines.svh"

module dark_mode_colour_remap_unit
  import dmcr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  output logic             result_valid_o,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [9:0]  cfg_data_i
);

  // Configuration registers.
  logic       high_contrast_q;
  logic [9:0] fore_level_q, fore_floor_q, back_level_q, back_ceiling_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_contrast_q <= 1'b0;
      fore_level_q    <= FORE_LEVEL_RST;
      fore_floor_q    <= FORE_FLOOR_RST;
      back_level_q    <= BACK_LEVEL_RST;
      back_ceiling_q  <= BACK_CEILING_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HIGH_CONTRAST: high_contrast_q <= cfg_data_i[0];
        REG_FORE_LEVEL:    fore_level_q    <= cfg_data_i;
        REG_FORE_FLOOR:    fore_floor_q    <= cfg_data_i;
        REG_BACK_LEVEL:    back_level_q    <= cfg_data_i;
        REG_BACK_CEILING:  back_ceiling_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits, one per stage.
  logic [LATENCY-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start_i && !busy_o};
    end
  end

  // ---------------- Stage 1: max, min, spread and hue numerator ----------
  logic [7:0] mx_d, mn_d, absnum_d;
  logic [1:0] sel_d;
  logic       neg_d;
  logic [8:0] sum_d, den_d, inv_sum_d;
  logic signed [8:0] num_d;

  logic       s1_cmd_q, s1_neg_q;
  logic [1:0] s1_sel_q;
  logic [8:0] s1_sum_q;
  logic [7:0] s1_d_q, s1_den_q, s1_absnum_q;

  always_comb begin
    mx_d = red_in_i;
    mn_d = red_in_i;
    if (green_in_i > mx_d) mx_d = green_in_i;
    if (blue_in_i > mx_d)  mx_d = blue_in_i;
    if (green_in_i < mn_d) mn_d = green_in_i;
    if (blue_in_i < mn_d)  mn_d = blue_in_i;
    sum_d     = {1'b0, mx_d} + {1'b0, mn_d};
    inv_sum_d = 9'd510 - sum_d;
    den_d     = (sum_d < inv_sum_d) ? sum_d : inv_sum_d;
    if (mx_d == red_in_i) begin
      sel_d = SEL_RED;
      num_d = $signed({1'b0, green_in_i}) - $signed({1'b0, blue_in_i});
    end else if (mx_d == green_in_i) begin
      sel_d = SEL_GREEN;
      num_d = $signed({1'b0, blue_in_i}) - $signed({1'b0, red_in_i});
    end else begin
      sel_d = SEL_BLUE;
      num_d = $signed({1'b0, red_in_i}) - $signed({1'b0, green_in_i});
    end
    neg_d    = num_d[8];
    absnum_d = neg_d ? 8'(-num_d) : num_d[7:0];
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q    <= command_i;
    s1_sel_q    <= sel_d;
    s1_neg_q    <= neg_d;
    s1_sum_q    <= sum_d;
    s1_d_q      <= mx_d - mn_d;
    s1_den_q    <= den_d[7:0];
    s1_absnum_q <= absnum_d;
  end

  // ---------------- Stage 2: lightness, quotient bits 16..11 -------------
  // Both quotients are below or equal to 1.0 since the numerator never
  // exceeds the divisor, so the top bit is a plain compare.
  logic [33:0] light_prod;
  logic [7:0]  h_rem2, s_rem2;
  logic [5:0]  h_bits2, s_bits2;
  logic [8:0]  st2h, st2s;

  logic       s2_cmd_q, s2_neg_q, s2_zero_q;
  logic [1:0] s2_sel_q;
  logic [16:0] s2_light_q;
  logic [7:0] s2_d_q, s2_den_q, s2_hrem_q, s2_srem_q;
  logic [5:0] s2_hq_q, s2_sq_q;

  always_comb begin
    light_prod = {16'b0, s1_sum_q} * {9'b0, RECIP_255};
    h_bits2[5] = (s1_absnum_q >= s1_d_q);
    h_rem2     = h_bits2[5] ? s1_absnum_q - s1_d_q : s1_absnum_q;
    s_bits2[5] = (s1_d_q >= s1_den_q);
    s_rem2     = s_bits2[5] ? s1_d_q - s1_den_q : s1_d_q;
    st2h = '0;
    st2s = '0;
    for (int k = 4; k >= 0; k--) begin
      st2h       = div_step(h_rem2, s1_d_q);
      h_bits2[k] = st2h[8];
      h_rem2     = st2h[7:0];
      st2s       = div_step(s_rem2, s1_den_q);
      s_bits2[k] = st2s[8];
      s_rem2     = st2s[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s2_cmd_q   <= s1_cmd_q;
    s2_neg_q   <= s1_neg_q;
    s2_sel_q   <= s1_sel_q;
    s2_zero_q  <= (s1_d_q == 8'd0);
    s2_light_q <= light_prod[33:17];
    s2_d_q     <= s1_d_q;
    s2_den_q   <= s1_den_q;
    s2_hrem_q  <= h_rem2;
    s2_srem_q  <= s_rem2;
    s2_hq_q    <= h_bits2;
    s2_sq_q    <= s_bits2;
  end

  // ---------------- Stage 3: new lightness, quotient bits 10..5 ----------
  logic [16:0] lim_d, newl_d;
  logic [7:0]  h_rem3, s_rem3;
  logic [5:0]  h_bits3, s_bits3;
  logic [8:0]  st3h, st3s;

  logic       s3_neg_q, s3_zero_q;
  logic [1:0] s3_sel_q;
  logic [16:0] s3_light_q;
  logic [7:0] s3_d_q, s3_den_q, s3_hrem_q, s3_srem_q;
  logic [11:0] s3_hq_q, s3_sq_q;

  always_comb begin
    if (s2_cmd_q == CMD_FORE) begin
      lim_d = {1'b0, fore_floor_q, 6'b0};
      if (high_contrast_q) begin
        newl_d = (s2_light_q < lim_d) ? lim_d : s2_light_q;
      end else begin
        newl_d = {1'b0, fore_level_q, 6'b0};
      end
    end else begin
      lim_d = {1'b0, back_ceiling_q, 6'b0};
      if (high_contrast_q) begin
        newl_d = (s2_light_q > lim_d) ? lim_d : s2_light_q;
      end else begin
        newl_d = {1'b0, back_level_q, 6'b0};
      end
    end
    h_rem3 = s2_hrem_q;
    s_rem3 = s2_srem_q;
    st3h   = '0;
    st3s   = '0;
    for (int k = 5; k >= 0; k--) begin
      st3h       = div_step(h_rem3, s2_d_q);
      h_bits3[k] = st3h[8];
      h_rem3     = st3h[7:0];
      st3s       = div_step(s_rem3, s2_den_q);
      s_bits3[k] = st3s[8];
      s_rem3     = st3s[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s3_neg_q   <= s2_neg_q;
    s3_zero_q  <= s2_zero_q;
    s3_sel_q   <= s2_sel_q;
    s3_light_q <= newl_d;
    s3_d_q     <= s2_d_q;
    s3_den_q   <= s2_den_q;
    s3_hrem_q  <= h_rem3;
    s3_srem_q  <= s_rem3;
    s3_hq_q    <= {s2_hq_q, h_bits3};
    s3_sq_q    <= {s2_sq_q, s_bits3};
  end

  // ---------------- Stage 4: quotient bits 4..0, chroma span -------------
  logic [7:0]  h_rem4, s_rem4;
  logic [4:0]  h_bits4, s_bits4;
  logic [8:0]  st4h, st4s;
  logic [17:0] twol_d;
  logic [16:0] span_d;

  logic        s4_neg_q;
  logic [1:0]  s4_sel_q;
  logic [16:0] s4_light_q, s4_span_q, s4_hq_q, s4_sat_q;

  always_comb begin
    h_rem4 = s3_hrem_q;
    s_rem4 = s3_srem_q;
    st4h   = '0;
    st4s   = '0;
    for (int k = 4; k >= 0; k--) begin
      st4h       = div_step(h_rem4, s3_d_q);
      h_bits4[k] = st4h[8];
      h_rem4     = st4h[7:0];
      st4s       = div_step(s_rem4, s3_den_q);
      s_bits4[k] = st4s[8];
      s_rem4     = st4s[7:0];
    end
    twol_d = {s3_light_q, 1'b0};
    span_d = (twol_d < 18'(ONE_Q16)) ? twol_d[16:0] : 17'(18'(TWO_Q16) - twol_d);
  end

  // A grey pixel has no hue and no saturation; the divider output is junk.
  always_ff @(posedge clk_i) begin
    s4_neg_q   <= s3_neg_q && !s3_zero_q;
    s4_sel_q   <= s3_sel_q;
    s4_light_q <= s3_light_q;
    s4_span_q  <= span_d;
    s4_hq_q    <= s3_zero_q ? 17'd0 : {s3_hq_q, h_bits4};
    s4_sat_q   <= s3_zero_q ? 17'd0 : {s3_sq_q, s_bits4};
  end

  // ---------------- Stage 5: hue, chroma -------------------------------
  logic [18:0] base_d, hue_d;
  logic signed [19:0] hdiff_d;
  logic [33:0] chroma_prod;

  logic [18:0] s5_hue_q;
  logic [16:0] s5_light_q, s5_chroma_q;

  always_comb begin
    case (s4_sel_q)
      SEL_RED:   base_d = 19'd0;
      SEL_GREEN: base_d = 19'(TWO_Q16);
      default:   base_d = 19'(2 * TWO_Q16);
    endcase
    hdiff_d = $signed({1'b0, base_d}) - $signed({3'b0, s4_hq_q});
    if (!s4_neg_q) begin
      hue_d = base_d + {2'b0, s4_hq_q};
    end else if (hdiff_d < 0) begin
      hue_d = 19'(hdiff_d + 20'sd393216);
    end else begin
      hue_d = hdiff_d[18:0];
    end
    chroma_prod = s4_span_q * s4_sat_q;
  end

  always_ff @(posedge clk_i) begin
    s5_hue_q    <= hue_d;
    s5_light_q  <= s4_light_q;
    s5_chroma_q <= chroma_prod[32:16];
  end

  // ---------------- Stage 6: second component and offset --------------
  logic [16:0] frac_d, wf_d;
  logic [33:0] x_prod;

  logic [2:0]  s6_sext_q;
  logic [16:0] s6_chroma_q, s6_x_q;
  logic signed [17:0] s6_m_q;

  always_comb begin
    frac_d = s5_hue_q[16:0];
    wf_d   = frac_d[16] ? 17'(18'(TWO_Q16) - {1'b0, frac_d}) : frac_d;
    x_prod = s5_chroma_q * wf_d;
  end

  always_ff @(posedge clk_i) begin
    s6_sext_q   <= s5_hue_q[18:16];
    s6_chroma_q <= s5_chroma_q;
    s6_x_q      <= x_prod[32:16];
    s6_m_q      <= $signed({1'b0, s5_light_q}) - $signed({2'b0, s5_chroma_q[16:1]});
  end

  // ---------------- Stage 7: channel placement and scaling -------------
  logic [16:0] cr_d, cg_d, cb_d;
  logic signed [18:0] vr_d, vg_d, vb_d;

  always_comb begin
    case (s6_sext_q)
      3'd0: begin cr_d = s6_chroma_q; cg_d = s6_x_q;      cb_d = '0;          end
      3'd1: begin cr_d = s6_x_q;      cg_d = s6_chroma_q; cb_d = '0;          end
      3'd2: begin cr_d = '0;          cg_d = s6_chroma_q; cb_d = s6_x_q;      end
      3'd3: begin cr_d = '0;          cg_d = s6_x_q;      cb_d = s6_chroma_q; end
      3'd4: begin cr_d = s6_x_q;      cg_d = '0;          cb_d = s6_chroma_q; end
      default: begin cr_d = s6_chroma_q; cg_d = '0;      cb_d = s6_x_q;      end
    endcase
    vr_d = $signed({2'b0, cr_d}) + 19'(s6_m_q);
    vg_d = $signed({2'b0, cg_d}) + 19'(s6_m_q);
    vb_d = $signed({2'b0, cb_d}) + 19'(s6_m_q);
  end

  always_ff @(posedge clk_i) begin
    red_out_o   <= to_byte(vr_d);
    green_out_o <= to_byte(vg_d);
    blue_out_o  <= to_byte(vb_d);
  end

  assign result_valid_o = vld_q[LATENCY-1];

  // ---------------- Assertions ------------------------------------------
  `DMCR_ASSERT_LAT(a_beat_out, start_i && !busy_o, LATENCY, result_valid_o,
                   "accepted pixel did not produce a result beat")
  `DMCR_ASSERT_IMP(a_no_spurious, result_valid_o, $past(start_i, LATENCY),
                   "result beat without an accepted pixel")
  `DMCR_ASSERT_LAT(a_grey_stays_grey,
                   start_i && red_in_i == green_in_i && green_in_i == blue_in_i,
                   LATENCY, red_out_o == green_out_o && green_out_o == blue_out_o,
                   "grey pixel came out coloured")
  `DMCR_ASSERT_IMP(a_sat_range, vld_q[3], s4_sat_q <= 17'd65536 && s4_hq_q <= 17'd65536,
                   "divider quotient above one")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// Dark mode colour remap unit testbench
// Drives pixels with or without random gaps, predicts each remapped pixel
// by an HSL round trip in fixed point, and checks every result beat in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import dmcr_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic       command_i;
  logic [7:0] red_in_i;
  logic [7:0] green_in_i;
  logic [7:0] blue_in_i;
  logic       result_valid_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [9:0] cfg_data_i;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       known;
    pixel_t     want;
  } vector_t;

  pixel_t     remap_fifo[$];
  int         n_errors;
  int         n_pixels;
  int         n_checked;
  logic       hc_q;
  logic [9:0] fore_level_q;
  logic [9:0] fore_floor_q;
  logic [9:0] back_level_q;
  logic [9:0] back_ceiling_q;

  dark_mode_colour_remap_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .result_valid_o(result_valid_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [7:0] q16_to_channel(longint v);
    if (v < 0) v = 0;
    if (v > ONE_Q16) v = ONE_Q16;
    return 8'((v * 255) >>> 16);
  endfunction

  function automatic pixel_t remap_pixel(logic cmd, logic [7:0] r8, logic [7:0] g8,
                                         logic [7:0] b8);
    longint r, g, b, mx, mn, d, sum, light, sat, hue, num, base, q, den;
    longint t, c, f, x, m, cr, cg, cb;
    pixel_t p;
    r = r8; g = g8; b = b8;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = mx + mn;
    light = (sum * ONE_Q16) / 510;
    sat = 0;
    hue = 0;
    if (d != 0) begin
      den = (sum < 510 - sum) ? sum : 510 - sum;
      sat = (d * ONE_Q16) / den;
      if (mx == r) begin
        num = g - b; base = 0;
      end else if (mx == g) begin
        num = b - r; base = TWO_Q16;
      end else begin
        num = r - g; base = 2 * TWO_Q16;
      end
      q = (abs_l(num) * ONE_Q16) / d;
      if (num < 0) begin
        hue = base - q;
        if (hue < 0) hue += SIX_Q16;
      end else begin
        hue = base + q;
      end
    end
    if (cmd == CMD_FORE) begin
      if (hc_q) begin
        if (light < (longint'(fore_floor_q) << 6)) light = longint'(fore_floor_q) << 6;
      end else begin
        light = longint'(fore_level_q) << 6;
      end
    end else begin
      if (hc_q) begin
        if (light > (longint'(back_ceiling_q) << 6)) light = longint'(back_ceiling_q) << 6;
      end else begin
        light = longint'(back_level_q) << 6;
      end
    end
    t = ONE_Q16 - abs_l(2 * light - ONE_Q16);
    c = (t * sat) / ONE_Q16;
    f = hue & 64'h1FFFF;
    x = (c * (ONE_Q16 - abs_l(f - ONE_Q16))) / ONE_Q16;
    m = light - c / 2;
    case (hue >>> 16)
      0: begin cr = c; cg = x; cb = 0; end
      1: begin cr = x; cg = c; cb = 0; end
      2: begin cr = 0; cg = c; cb = x; end
      3: begin cr = 0; cg = x; cb = c; end
      4: begin cr = x; cg = 0; cb = c; end
      default: begin cr = c; cg = 0; cb = x; end
    endcase
    p.red   = q16_to_channel(cr + m);
    p.green = q16_to_channel(cg + m);
    p.blue  = q16_to_channel(cb + m);
    return p;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [9:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_HIGH_CONTRAST: hc_q = data[0];
      REG_FORE_LEVEL:    fore_level_q = data;
      REG_FORE_FLOOR:    fore_floor_q = data;
      REG_BACK_LEVEL:    back_level_q = data;
      REG_BACK_CEILING:  back_ceiling_q = data;
      default: ;
    endcase
  endtask

  // Waits for all pixels in flight, then lets the pipeline drain fully.
  task automatic drain_pipe();
    start_i <= 1'b0;
    while (remap_fifo.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 3) @(posedge clk_i);
  endtask

  task automatic send_pixel(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_t p;
    start_i   <= 1'b1;
    command_i <= cmd;
    red_in_i  <= r;
    green_in_i <= g;
    blue_in_i <= b;
    do @(posedge clk_i); while (busy_o);
    p = remap_pixel(cmd, r, g, b);
    remap_fifo.push_back(p);
    n_pixels++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (n != 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Result side: the block cannot be stalled, so every strobe is one beat.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && result_valid_o) begin
      if (remap_fifo.size() == 0) begin
        $error("result beat with no pixel outstanding");
        n_errors++;
      end else begin
        want = remap_fifo.pop_front();
        n_checked++;
        if (red_out_o !== want.red) begin
          $error("red_out expected %0d got %0d", want.red, red_out_o);
          n_errors++;
        end
        if (green_out_o !== want.green) begin
          $error("green_out expected %0d got %0d", want.green, green_out_o);
          n_errors++;
        end
        if (blue_out_o !== want.blue) begin
          $error("blue_out expected %0d got %0d", want.blue, blue_out_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    vector_t vectors[$];
    vector_t v;
    pixel_t  got;
    int      burst;
    int      phase;
    logic    fast;
    n_errors = 0;
    n_pixels = 0;
    n_checked = 0;
    hc_q = 1'b0;
    fore_level_q = FORE_LEVEL_RST;
    fore_floor_q = FORE_FLOOR_RST;
    back_level_q = BACK_LEVEL_RST;
    back_ceiling_q = BACK_CEILING_RST;
    rst_ni = 1'b0;
    start_i = 1'b0;
    command_i = CMD_FORE;
    red_in_i = '0;
    green_in_i = '0;
    blue_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_HIGH_CONTRAST;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Greys at reset settings have an obvious answer:
    // fore level 768 is 0.75 -> 191, back level 205 -> 51.
    vectors = '{
      '{CMD_FORE, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd191, 8'd191, 8'd191}},
      '{CMD_FORE, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd191, 8'd191, 8'd191}},
      '{CMD_BACK, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd51,  8'd51,  8'd51}},
      '{CMD_BACK, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd51,  8'd51,  8'd51}},
      '{CMD_FORE, 8'd255, 8'd0,   8'd0,   1'b0, '0},
      '{CMD_FORE, 8'd0,   8'd255, 8'd0,   1'b0, '0},
      '{CMD_FORE, 8'd0,   8'd0,   8'd255, 1'b0, '0},
      '{CMD_BACK, 8'd255, 8'd255, 8'd0,   1'b0, '0},
      '{CMD_BACK, 8'd0,   8'd255, 8'd255, 1'b0, '0},
      '{CMD_BACK, 8'd255, 8'd0,   8'd255, 1'b0, '0},
      '{CMD_FORE, 8'd255, 8'd0,   8'd1,   1'b0, '0},
      '{CMD_FORE, 8'd255, 8'd255, 8'd254, 1'b0, '0},
      '{CMD_BACK, 8'd1,   8'd0,   8'd0,   1'b0, '0},
      '{CMD_BACK, 8'd128, 8'd127, 8'd200, 1'b0, '0},
      '{CMD_FORE, 8'd170, 8'd85,  8'd170, 1'b0, '0},
      '{CMD_FORE, 8'd128, 8'd128, 8'd128, 1'b0, '0}
    };
    foreach (vectors[i]) begin
      v = vectors[i];
      send_pixel(v.cmd, v.red, v.green, v.blue);
      if (v.known) begin
        got = remap_fifo[$];
        if (got !== v.want) begin
          $error("table row %0d expected %h got %h", i, v.want, got);
          n_errors++;
        end
      end
    end
    drain_pipe();

    // Random phases, each with a fresh setting; extremes come first.
    for (phase = 0; phase < 16; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_HIGH_CONTRAST, 10'd1);
          write_reg(REG_FORE_FLOOR, 10'd0);
          write_reg(REG_BACK_CEILING, 10'd1023);
        end
        1: begin
          write_reg(REG_FORE_FLOOR, 10'd1023);
          write_reg(REG_BACK_CEILING, 10'd0);
        end
        2: begin
          write_reg(REG_HIGH_CONTRAST, 10'd0);
          write_reg(REG_FORE_LEVEL, 10'd1023);
          write_reg(REG_BACK_LEVEL, 10'd0);
        end
        3: begin
          write_reg(REG_FORE_LEVEL, 10'd0);
          write_reg(REG_BACK_LEVEL, 10'd1023);
        end
        4: begin
          write_reg(REG_FORE_LEVEL, 10'd512);
          write_reg(REG_BACK_LEVEL, 10'd512);
        end
        default: begin
          write_reg(REG_HIGH_CONTRAST, 10'($urandom_range(0, 1)));
          write_reg(REG_FORE_LEVEL, 10'($urandom));
          write_reg(REG_FORE_FLOOR, 10'($urandom));
          write_reg(REG_BACK_LEVEL, 10'($urandom));
          write_reg(REG_BACK_CEILING, 10'($urandom));
        end
      endcase
      fast = (phase % 4 == 3);
      for (burst = 0; burst < 100; burst++) begin
        send_pixel(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        if (!fast) idle_gap();
      end
      drain_pipe();
    end

    $display("Covered %0d pixels, %0d results checked, over 16 register settings",
             n_pixels, n_checked);
    $display("including high-contrast limits, forced levels and their extremes.");
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
